FILE: rtl/core/cpf_pkg.sv
package cpf_pkg;

	localparam int SHOWN_PAYLOAD  = 4;
	localparam int SLOT_W         = 3;
	localparam int BPP_DEFAULT    = 4;
	localparam int MID_DEPTH      = 2;
	localparam int OUT_DEPTH      = 2;

	// one classified byte, front to back
	typedef struct packed {
		logic [15:0]       length;
		logic [7:0]        seq;
		logic              emit;
		logic              last;
		logic [SLOT_W-1:0] slot;
		logic [7:0]        data;
	} mid_entry_t;

	// one finished packet
	typedef struct packed {
		logic [15:0]                     length;
		logic [SHOWN_PAYLOAD-1:0][7:0]   payload;
		logic [7:0]                      seq;
		logic [7:0]                      sum_chk;
		logic [7:0]                      xor_chk;
		logic                            final_pkt;
	} out_pkt_t;

endpackage

FILE: rtl/core/cpf_fifo.sv
module cpf_fifo import cpf_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = MID_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr, do_rd;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("fifo count beyond depth");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && !full && !(rd_en && !empty)) |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("fifo write lost");

	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && !empty && !(wr_en && !full)) |=> (count_q == $past(count_q) - CNT_W'(1)))
		else $error("fifo read lost");

endmodule

FILE: rtl/core/cpf_front.sv
module cpf_front import cpf_pkg::*; #(
	parameter int BYTES_PER_PACKET = BPP_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        take,
	input  logic [7:0]  data_byte,
	input  logic [15:0] msg_len,
	output logic        entry_valid,
	output mid_entry_t  entry
);

	logic [SLOT_W-1:0] slot_q;
	logic [15:0]       taken_q;
	logic [7:0]        pkt_q;
	logic [15:0]       taken_n;
	logic              last, slot_end, emit;

	always_comb begin
		taken_n     = taken_q + 16'd1;
		last        = (taken_n >= msg_len);
		slot_end    = (slot_q == SLOT_W'(BYTES_PER_PACKET - 1));
		emit        = last || slot_end;
		entry_valid = take && (msg_len != 16'd0);
		entry.length = msg_len;
		entry.seq    = pkt_q;
		entry.emit   = emit;
		entry.last   = last;
		entry.slot   = slot_q;
		entry.data   = data_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q  <= '0;
			taken_q <= '0;
			pkt_q   <= '0;
		end else if (entry_valid) begin
			slot_q <= emit ? '0 : slot_q + SLOT_W'(1);
			if (last) begin
				taken_q <= '0;
				pkt_q   <= '0;
			end else begin
				taken_q <= taken_n;
				if (emit) begin
					pkt_q <= pkt_q + 8'd1;
				end
			end
		end
	end

endmodule

FILE: rtl/core/cpf_back.sv
module cpf_back import cpf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  mid_entry_t entry,
	output out_pkt_t   pkt
);

	logic [SHOWN_PAYLOAD-1:0][7:0] held_q, held_n;
	logic [7:0]                    sum_q, xor_q, sum_n, xor_n;

	always_comb begin
		for (int k = 0; k < SHOWN_PAYLOAD; k++) begin
			held_n[k] = (entry.slot == SLOT_W'(k)) ? entry.data : held_q[k];
		end
		sum_n         = sum_q + entry.data;
		xor_n         = xor_q ^ entry.data;
		pkt.length    = entry.length;
		pkt.payload   = held_n;
		pkt.seq       = entry.seq;
		pkt.sum_chk   = sum_n + entry.seq;
		pkt.xor_chk   = xor_n ^ entry.seq;
		pkt.final_pkt = entry.last;
	end

	// running packet image; cleared whenever a packet leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			sum_q  <= '0;
			xor_q  <= '0;
		end else if (take) begin
			if (entry.emit) begin
				held_q <= '0;
				sum_q  <= '0;
				xor_q  <= '0;
			end else begin
				held_q <= held_n;
				sum_q  <= sum_n;
				xor_q  <= xor_n;
			end
		end
	end

endmodule

FILE: rtl/core/checked_packet_framer.sv
// checked_packet_framer: groups message bytes into checked packets.
// Input queue side: drive data_byte and push; a transfer happens on a rising
// edge with push high and full low. Bytes are taken one per cycle unless full.
// Result queue side: while empty is low the oldest packet sits on the result
// ports; a transfer happens on a rising edge with pop high and empty low.
// Config: cfg_we high on an edge loads message_length; write only while idle.
// Latency: a packet that closes on byte N reaches the result ports from
// the transfer of byte N via front logic -> two-entry classify queue -> back
// logic -> two-entry result queue; byte N is registered only in the queues.
// Throughput is one byte per cycle as long as the result side keeps
// popping; the result queue decouples the back stage from pauses in popping.
// When the result queue fills the back stage holds, the middle queue fills
// and full rises; bytes already taken are never dropped.
// With message_length zero, bytes are taken and discarded.
// Reset (arst_n low) empties both queues and clears counters, the packet
// image and message_length.
module checked_packet_framer import cpf_pkg::*; #(
	parameter int BYTES_PER_PACKET = BPP_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] message_length,
	input  logic        push,
	input  logic [7:0]  data_byte,
	output logic        full,
	input  logic        pop,
	output logic        empty,
	output logic [15:0] length_field,
	output logic [7:0]  payload_0,
	output logic [7:0]  payload_1,
	output logic [7:0]  payload_2,
	output logic [7:0]  payload_3,
	output logic [7:0]  sequence_number,
	output logic [7:0]  sum_check,
	output logic [7:0]  xor_check,
	output logic        final_packet
);

	logic [15:0] len_q;
	logic        fe_valid;
	mid_entry_t  fe_entry, mid_head;
	logic        mid_empty, back_take, out_full;
	out_pkt_t    back_pkt, out_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (cfg_we) begin
			len_q <= message_length;
		end
	end

	// front: counts bytes, marks packet ends
	cpf_front #(
		.BYTES_PER_PACKET(BYTES_PER_PACKET)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (push && !full),
		.data_byte  (data_byte),
		.msg_len    (len_q),
		.entry_valid(fe_valid),
		.entry      (fe_entry)
	);

	cpf_fifo #(
		.WIDTH($bits(mid_entry_t)),
		.DEPTH(MID_DEPTH)
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (fe_valid),
		.wr_data(fe_entry),
		.full   (full),
		.rd_en  (back_take),
		.rd_data(mid_head),
		.empty  (mid_empty)
	);

	// back stalls only on a packet-closing byte with no room downstream
	assign back_take = !mid_empty && (!mid_head.emit || !out_full);

	cpf_back u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.take  (back_take),
		.entry (mid_head),
		.pkt   (back_pkt)
	);

	cpf_fifo #(
		.WIDTH($bits(out_pkt_t)),
		.DEPTH(OUT_DEPTH)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (back_take && mid_head.emit),
		.wr_data(back_pkt),
		.full   (out_full),
		.rd_en  (pop),
		.rd_data(out_head),
		.empty  (empty)
	);

	assign length_field    = out_head.length;
	assign payload_0       = out_head.payload[0];
	assign payload_1       = out_head.payload[1];
	assign payload_2       = out_head.payload[2];
	assign payload_3       = out_head.payload[3];
	assign sequence_number = out_head.seq;
	assign sum_check       = out_head.sum_chk;
	assign xor_check       = out_head.xor_chk;
	assign final_packet    = out_head.final_pkt;

endmodule

FILE: bench/checked_packet_framer_tb.sv
`timescale 1ns / 100ps

module checked_packet_framer_tb;
	import cpf_pkg::*;

	localparam int BYTES_PER_PACKET = BPP_DEFAULT;
	// Packets pass through both internal queues after the closing byte; wait
	// this long before touching message_length or ending the run.
	localparam int SETTLE_CYCLES = 8;
	// Receiver hold-off long enough to back up both internal queues.
	localparam int LONG_HOLD = 90;
	// Bytes framed at a nonzero length before the stimulus stops.
	localparam int ITEM_TARGET = 1530;
	// 1032 bytes at four per packet takes the sequence number past 255.
	localparam int WRAP_BYTES = 1032;

	typedef enum int {
		POP_ALWAYS,
		POP_COIN,
		POP_ONE_IN_FOUR,
		POP_MOSTLY
	} pop_mode_e;

	// Framing predictor plus the queue of packets it still expects.
	class framer_scoreboard;
		logic [15:0] msg_len;
		logic [7:0]  held [8];
		int unsigned slot;
		logic [15:0] taken;
		logic [7:0]  pkt_no;
		logic [7:0]  sum_acc;
		logic [7:0]  xor_acc;
		out_pkt_t    packets_due [$];
		int          errors;
		int          used_bytes;
		int          dropped_bytes;
		int          packets_seen;
		int          finals_seen;
		int          wraps_seen;
		int          settings_seen;

		function new();
			msg_len = '0;
			taken   = '0;
			pkt_no  = '0;
			clear_packet();
		endfunction

		function void clear_packet();
			foreach (held[k])
				held[k] = '0;
			slot    = 0;
			sum_acc = '0;
			xor_acc = '0;
		endfunction

		function void write_length(logic [15:0] v);
			msg_len = v;
			settings_seen++;
		endfunction

		function int pending();
			return packets_due.size();
		endfunction

		// One byte transfer on the input side.
		function void note_byte(logic [7:0] b);
			out_pkt_t pkt;
			logic     ends_msg;
			if (msg_len == 0) begin
				dropped_bytes++;
				return;
			end
			used_bytes++;
			if (slot < 8)
				held[slot] = b;
			slot++;
			sum_acc += b;
			xor_acc ^= b;
			taken++;
			ends_msg = (taken >= msg_len);
			if (slot < BYTES_PER_PACKET && !ends_msg)
				return;
			pkt.length = msg_len;
			for (int k = 0; k < SHOWN_PAYLOAD; k++)
				pkt.payload[k] = (k < BYTES_PER_PACKET && k < slot && k < 8) ? held[k] : 8'h00;
			pkt.seq       = pkt_no;
			pkt.sum_chk   = sum_acc + pkt_no;
			pkt.xor_chk   = xor_acc ^ pkt_no;
			pkt.final_pkt = ends_msg;
			packets_due.push_back(pkt);
			clear_packet();
			pkt_no++;
			if (ends_msg) begin
				taken  = '0;
				pkt_no = '0;
			end
		endfunction

		function void compare_field(string name, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				errors++;
			end
		endfunction

		// One packet transfer on the result side.
		function void check_packet(out_pkt_t got);
			out_pkt_t want;
			if (packets_due.size() == 0) begin
				$error("packet seq %0h popped with none expected", got.seq);
				errors++;
				return;
			end
			want = packets_due.pop_front();
			packets_seen++;
			if (want.final_pkt)
				finals_seen++;
			if (want.seq == 8'hFF)
				wraps_seen++;
			compare_field("length_field", want.length, got.length);
			for (int k = 0; k < SHOWN_PAYLOAD; k++)
				compare_field($sformatf("payload_%0d", k), want.payload[k], got.payload[k]);
			compare_field("sequence_number", want.seq, got.seq);
			compare_field("sum_check", want.sum_chk, got.sum_chk);
			compare_field("xor_check", want.xor_chk, got.xor_chk);
			compare_field("final_packet", want.final_pkt, got.final_pkt);
		endfunction
	endclass

	logic        clk            = 1'b0;
	logic        arst_n         = 1'b0;
	logic        cfg_we         = 1'b0;
	logic [15:0] message_length = '0;
	logic        push           = 1'b0;
	logic [7:0]  data_byte      = '0;
	logic        full;
	logic        pop            = 1'b0;
	logic        empty;
	logic [15:0] length_field;
	logic [7:0]  payload_0;
	logic [7:0]  payload_1;
	logic [7:0]  payload_2;
	logic [7:0]  payload_3;
	logic [7:0]  sequence_number;
	logic [7:0]  sum_check;
	logic [7:0]  xor_check;
	logic        final_packet;

	framer_scoreboard sb = new();
	out_pkt_t         seen_pkt;
	int               full_stalls   = 0;
	int               hold_requests = 0;

	checked_packet_framer #(
		.BYTES_PER_PACKET(BYTES_PER_PACKET)
	) u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.message_length (message_length),
		.push           (push),
		.data_byte      (data_byte),
		.full           (full),
		.pop            (pop),
		.empty          (empty),
		.length_field   (length_field),
		.payload_0      (payload_0),
		.payload_1      (payload_1),
		.payload_2      (payload_2),
		.payload_3      (payload_3),
		.sequence_number(sequence_number),
		.sum_check      (sum_check),
		.xor_check      (xor_check),
		.final_packet   (final_packet)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Monitor: every input and result transfer is sampled at the edge it
	// happens on. Drivers only change things via NBAs at the same edge, so
	// the values read here are the pre-edge ones.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				sb.write_length(message_length);
			if (push && !full)
				sb.note_byte(data_byte);
			if (push && full)
				full_stalls++;
			if (pop && !empty) begin
				seen_pkt.length     = length_field;
				seen_pkt.payload[0] = payload_0;
				seen_pkt.payload[1] = payload_1;
				seen_pkt.payload[2] = payload_2;
				seen_pkt.payload[3] = payload_3;
				seen_pkt.seq        = sequence_number;
				seen_pkt.sum_chk    = sum_check;
				seen_pkt.xor_chk    = xor_check;
				seen_pkt.final_pkt  = final_packet;
				sb.check_packet(seen_pkt);
			end
		end
	end

	// Offer one byte and hold it until the block takes it.
	task automatic offer(input logic [7:0] b);
		push      <= 1'b1;
		data_byte <= b;
		do @(posedge clk); while (full);
	endtask

	task automatic idle_for(input int cycles);
		push <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Random bytes in bursts of random length, random gaps between bursts.
	task automatic send_bytes(input int count);
		int burst;
		burst = 0;
		for (int i = 0; i < count; i++) begin
			if (burst == 0) begin
				burst = $urandom_range(1, 24);
				if ($urandom_range(0, 3) != 0)
					idle_for($urandom_range(1, 8));
			end
			offer(8'($urandom()));
			burst--;
		end
	endtask

	// Stop sending, let every expected packet arrive, then let the pipeline
	// settle: a trailing partial packet produces nothing to wait on.
	// Polled on the falling edge so the monitor has already run.
	task automatic drain();
		push <= 1'b0;
		do @(negedge clk); while (sb.pending() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_length(input logic [15:0] v);
		cfg_we         <= 1'b1;
		message_length <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Result side: pop pattern changes after a random stretch; one long
	// hold-off on request so the block backs up and raises full.
	initial begin : result_side
		pop_mode_e mode;
		int        stretch;
		int        holds_done;
		mode       = POP_ALWAYS;
		stretch    = 0;
		holds_done = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_requests != holds_done) begin
				pop <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				holds_done++;
			end
			if (stretch == 0) begin
				mode    = pop_mode_e'($urandom_range(0, 3));
				stretch = $urandom_range(10, 80);
			end
			stretch--;
			case (mode)
				POP_ALWAYS:      pop <= 1'b1;
				POP_COIN:        pop <= ($urandom_range(0, 1) == 1);
				POP_ONE_IN_FOUR: pop <= (stretch % 4 == 0);
				default:         pop <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	initial begin : stimulus
		int          pick;
		int          count;
		int          rest;
		logic [15:0] len;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Length still zero from reset: bytes are taken and dropped.
		offer(8'h5A);
		offer(8'hA5);
		drain();

		// One-byte messages: every byte is a final packet, padded.
		set_length(16'd1);
		offer(8'hFF);
		offer(8'h00);
		drain();

		// Full packet of all-ones, then a padded two-byte tail.
		set_length(16'd6);
		repeat (4) offer(8'hFF);
		offer(8'h80);
		offer(8'h01);
		drain();

		// Length dropped below the bytes already taken: next byte closes it.
		set_length(16'd9);
		offer(8'h12);
		offer(8'h34);
		drain();
		set_length(16'd1);
		offer(8'h56);
		drain();

		// Largest length, then zero with a message still open.
		set_length(16'hFFFF);
		offer(8'h7F);
		offer(8'hFE);
		offer(8'h01);
		offer(8'h80);
		drain();
		set_length(16'd0);
		offer(8'h33);
		drain();

		// Long message: sequence number wraps, and the receiver holds off
		// long enough for full to push back on the sender.
		set_length(16'hFFFF);
		hold_requests <= hold_requests + 1;
		send_bytes(WRAP_BYTES);
		drain();

		// Random phases, mostly whole messages with random content; some
		// leave a message open so the next length change cuts it short.
		while (sb.used_bytes < ITEM_TARGET) begin
			pick = $urandom_range(0, 19);
			case (pick)
				0: begin
					len   = 16'd0;
					count = $urandom_range(1, 6);
				end
				1: begin
					len   = 16'd1;
					count = $urandom_range(1, 12);
				end
				2: begin
					len   = 16'hFFFF;
					count = $urandom_range(1, 30);
				end
				3: begin
					len   = 16'($urandom());
					count = $urandom_range(1, 30);
				end
				default: begin
					len   = 16'($urandom_range(2, 24));
					rest  = (len > sb.taken) ? len - sb.taken : 1;
					count = rest + len * $urandom_range(0, 3);
					if ($urandom_range(0, 4) == 0)
						count += $urandom_range(1, len - 1);
				end
			endcase
			set_length(len);
			send_bytes(count);
			drain();
		end

		$display("Framed %0d bytes (%0d dropped at zero length) over %0d length settings.",
			sb.used_bytes, sb.dropped_bytes, sb.settings_seen);
		$display("Checked %0d packets, %0d closing a message; seq wrapped %0d times;",
			sb.packets_seen, sb.finals_seen, sb.wraps_seen);
		$display("%0d cycles held by full.", full_stalls);
		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Hard stop well past the slowest legal run.
	initial begin : watchdog
		#10ms;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/cpf_pkg.sv
rtl/core/cpf_fifo.sv
rtl/core/cpf_front.sv
rtl/core/cpf_back.sv
rtl/core/checked_packet_framer.sv
bench/checked_packet_framer_tb.sv
